[design/bsr_pkg.sv]
// Shared constants, payload types and control types of the byte stream reassembler.
`timescale 1ns / 1ps
package bsr_pkg;

  // Byte store depth; a power of two, a position maps to its low bits.
  localparam int CAPACITY = 32;
  localparam int MAX_OUT  = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int N_W      = $clog2(MAX_OUT + 1);
  localparam int SUM_W    = ((CNT_W > N_W) ? CNT_W : N_W) + 1;
  localparam int POS_W    = 33;
  localparam int CFG_W    = 6;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  localparam logic FUNC_SEGMENT = 1'b0;
  localparam logic FUNC_CONSUME = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] stream_index;
    logic [7:0]  data_byte;
    logic        no_byte;
    logic        ends_stream;
    logic [5:0]  consume_count;
  } item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_closed;
    logic [5:0] pending_bytes;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_FINISH,
    ST_READ,
    ST_EMIT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic latch;
    logic apply;
    logic scan;
    logic finish;
    logic read;
    logic emit;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_go;
    logic run_empty;
    logic run_last;
  } ctrl_stat_t;

endpackage

[design/byte_stream_reassembler_unit.sv]
// Top level of the byte stream reassembler: controller, datapath and ports.
//
// An item is taken when start is high and busy is low; busy then stays high until the
// item's last result has been shown. Results appear on result, marked by result_strobe,
// and cannot be held off. An item that releases nothing gives one status result; an item
// that releases n bytes gives n byte results. The controller first applies the item, then
// runs the scan that walks the valid bitmap from the next expected position one slot per
// cycle, then updates the stream state, and then, for each released byte, does a
// registered read of the byte store followed by the result.
// stream_closed and pending_bytes show the state after the whole item on every result.
// The capacity register is written over cfg_valid/cfg_ready, which is ready while idle.
`timescale 1ns / 1ps
module byte_stream_reassembler_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  bsr_pkg::item_t            item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bsr_pkg::CFG_W-1:0] cfg_data,
  output logic                      result_strobe,
  output bsr_pkg::result_t          result
);

  bsr_pkg::ctrl_cmd_t  cmd;
  bsr_pkg::ctrl_stat_t stat;

  assign cfg_ready = !busy;

  bsr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  bsr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_strobe(result_strobe)
  );

endmodule

[design/bsr_ram.sv]
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/bsr_ctrl.sv]
// Controller state machine: sequences apply, scan, finish and the release of bytes.
`timescale 1ns / 1ps
module bsr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bsr_pkg::ctrl_stat_t stat,
  output logic                busy,
  output bsr_pkg::ctrl_cmd_t  cmd
);

  bsr_pkg::state_t state;
  bsr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bsr_pkg::ST_IDLE: begin
        if (start) state_next = bsr_pkg::ST_APPLY;
      end
      bsr_pkg::ST_APPLY:  state_next = bsr_pkg::ST_SCAN;
      bsr_pkg::ST_SCAN: begin
        if (!stat.scan_go) state_next = bsr_pkg::ST_FINISH;
      end
      bsr_pkg::ST_FINISH: begin
        state_next = stat.run_empty ? bsr_pkg::ST_REPORT : bsr_pkg::ST_READ;
      end
      bsr_pkg::ST_READ:   state_next = bsr_pkg::ST_EMIT;
      bsr_pkg::ST_EMIT: begin
        state_next = stat.run_last ? bsr_pkg::ST_IDLE : bsr_pkg::ST_READ;
      end
      bsr_pkg::ST_REPORT: state_next = bsr_pkg::ST_IDLE;
      default:            state_next = bsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      bsr_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      bsr_pkg::ST_APPLY:  cmd.apply  = 1'b1;
      bsr_pkg::ST_SCAN:   cmd.scan   = 1'b1;
      bsr_pkg::ST_FINISH: cmd.finish = 1'b1;
      bsr_pkg::ST_READ:   cmd.read   = 1'b1;
      bsr_pkg::ST_EMIT:   cmd.emit   = 1'b1;
      bsr_pkg::ST_REPORT: cmd.report = 1'b1;
      default:            busy       = 1'b0;
    endcase
  end

  // A result strobe never appears while the block is taking a new item.
  a_no_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(cmd.emit || cmd.report))
    else $error("result strobe while idle");

  a_scan_after_apply: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> cmd.scan)
    else $error("apply not followed by scan");

  a_latch_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> cmd.apply)
    else $error("accepted item not applied");

endmodule

[design/bsr_datapath.sv]
// Datapath: stream state, valid bitmap, byte store, scan counter and result forming.
`timescale 1ns / 1ps
module bsr_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  bsr_pkg::ctrl_cmd_t           cmd,
  output bsr_pkg::ctrl_stat_t          stat,
  input  bsr_pkg::item_t               item,
  input  logic                         cfg_wr,
  input  logic [bsr_pkg::CFG_W-1:0]    cfg_data,
  output bsr_pkg::result_t             result,
  output logic                         result_strobe
);

  // stream state (reset)
  logic [bsr_pkg::POS_W-1:0]    next_expected;
  logic [bsr_pkg::CNT_W-1:0]    writer_fill;
  logic                         end_known;
  logic [bsr_pkg::POS_W-1:0]    end_position;
  logic                         closed_flag;
  logic [bsr_pkg::CNT_W-1:0]    pending_total;
  logic [bsr_pkg::CFG_W-1:0]    cap_reg;
  logic [bsr_pkg::CAPACITY-1:0] mark;

  // per item working registers
  bsr_pkg::item_t               item_q;
  logic [bsr_pkg::N_W-1:0]      run_cnt;
  logic [bsr_pkg::POS_W-1:0]    scan_pos;
  logic [bsr_pkg::SLOT_W-1:0]   rd_ptr;
  logic [bsr_pkg::N_W-1:0]      left;

  logic [bsr_pkg::CNT_W-1:0]    cap_eff;
  logic [bsr_pkg::CNT_W-1:0]    room;
  logic [bsr_pkg::POS_W-1:0]    ext_pos;
  logic [bsr_pkg::POS_W-1:0]    diff;
  logic [bsr_pkg::SLOT_W-1:0]   wslot;
  logic                         in_win;
  logic                         byte_ok;
  logic [7:0]                   rdata;

  always_comb begin
    if (int'(cap_reg) < bsr_pkg::CAPACITY) begin
      cap_eff = bsr_pkg::CNT_W'(cap_reg);
    end else begin
      cap_eff = bsr_pkg::CNT_W'(bsr_pkg::CAPACITY);
    end
    room    = (writer_fill < cap_eff) ? (cap_eff - writer_fill) : '0;
    ext_pos = {1'b0, item_q.stream_index};
    diff    = ext_pos - next_expected;
    wslot   = item_q.stream_index[bsr_pkg::SLOT_W-1:0];
    in_win  = (ext_pos >= next_expected) && (diff < bsr_pkg::POS_W'(room));
    byte_ok = (item_q.func == bsr_pkg::FUNC_SEGMENT) && !closed_flag &&
              !item_q.no_byte && in_win && !mark[wslot];
  end

  always_comb begin
    stat.scan_go = (run_cnt < bsr_pkg::N_W'(bsr_pkg::MAX_OUT)) &&
                   !scan_pos[bsr_pkg::POS_W-1] &&
                   ((bsr_pkg::SUM_W'(writer_fill) + bsr_pkg::SUM_W'(run_cnt)) <
                    bsr_pkg::SUM_W'(cap_eff)) &&
                   mark[scan_pos[bsr_pkg::SLOT_W-1:0]];
    stat.run_empty = (run_cnt == '0);
    stat.run_last  = (left == bsr_pkg::N_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= '0;
      writer_fill   <= '0;
      end_known     <= 1'b0;
      end_position  <= '0;
      closed_flag   <= 1'b0;
      pending_total <= '0;
      cap_reg       <= bsr_pkg::CFG_RESET;
      mark          <= '0;
    end else begin
      if (cfg_wr) begin
        cap_reg <= cfg_data;
      end
      if (cmd.apply) begin
        if (item_q.func == bsr_pkg::FUNC_CONSUME) begin
          if (bsr_pkg::SUM_W'(item_q.consume_count) < bsr_pkg::SUM_W'(writer_fill)) begin
            writer_fill <= bsr_pkg::CNT_W'(bsr_pkg::SUM_W'(writer_fill) -
                                           bsr_pkg::SUM_W'(item_q.consume_count));
          end else begin
            writer_fill <= '0;
          end
        end else if (!closed_flag) begin
          if (byte_ok) begin
            mark[wslot]   <= 1'b1;
            pending_total <= pending_total + bsr_pkg::CNT_W'(1);
          end
          if (item_q.ends_stream) begin
            end_known    <= 1'b1;
            end_position <= ext_pos + bsr_pkg::POS_W'(!item_q.no_byte);
          end
        end
      end
      if (cmd.finish) begin
        next_expected <= scan_pos;
        writer_fill   <= bsr_pkg::CNT_W'(bsr_pkg::SUM_W'(writer_fill) +
                                         bsr_pkg::SUM_W'(run_cnt));
        if (bsr_pkg::SUM_W'(pending_total) > bsr_pkg::SUM_W'(run_cnt)) begin
          pending_total <= bsr_pkg::CNT_W'(bsr_pkg::SUM_W'(pending_total) -
                                           bsr_pkg::SUM_W'(run_cnt));
        end else begin
          pending_total <= '0;
        end
        if (end_known && (scan_pos == end_position)) begin
          closed_flag <= 1'b1;
        end
      end
      if (cmd.read) begin
        mark[rd_ptr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_q <= item;
    end
    if (cmd.apply) begin
      run_cnt  <= '0;
      scan_pos <= next_expected;
    end
    if (cmd.scan && stat.scan_go) begin
      run_cnt  <= run_cnt + bsr_pkg::N_W'(1);
      scan_pos <= scan_pos + bsr_pkg::POS_W'(1);
    end
    if (cmd.finish) begin
      rd_ptr <= next_expected[bsr_pkg::SLOT_W-1:0];
      left   <= run_cnt;
    end
    if (cmd.emit) begin
      rd_ptr <= rd_ptr + bsr_pkg::SLOT_W'(1);
      left   <= left - bsr_pkg::N_W'(1);
    end
  end

  bsr_ram #(
    .WIDTH(8),
    .DEPTH(bsr_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (cmd.apply && byte_ok),
    .waddr(wslot),
    .wdata(item_q.data_byte),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  always_comb begin
    result_strobe        = cmd.emit || cmd.report;
    result.out_valid     = cmd.emit;
    result.out_byte      = cmd.emit ? rdata : 8'd0;
    result.last_of_run   = cmd.emit ? stat.run_last : 1'b1;
    result.stream_closed = closed_flag;
    result.pending_bytes = 6'(pending_total);
  end

  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    closed_flag |=> closed_flag)
    else $error("closed flag dropped");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_total <= bsr_pkg::CNT_W'(bsr_pkg::CAPACITY))
    else $error("pending count beyond store depth");

  // The run found by the scan must start at a held byte.
  a_run_head_held: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && !stat.run_empty) |-> mark[next_expected[bsr_pkg::SLOT_W-1:0]])
    else $error("release run starts at an empty slot");

  a_read_held: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> mark[rd_ptr])
    else $error("release of an empty slot");

endmodule

[test/byte_stream_reassembler_unit_test.sv]
// Self-checking testbench for the byte stream reassembler: directed table, random traffic, then stream close.
`timescale 1ns / 1ps
module byte_stream_reassembler_unit_test;
  import bsr_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 120;
  localparam int N_PHASES    = 7;
  localparam int N_DIRECTED  = 18;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } step_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  item_t            item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             result_strobe;
  result_t          result;

  byte_stream_reassembler_unit u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .result(result)
  );

  // Reassembly state as the block should hold it
  logic [7:0]       held_byte [CAPACITY];
  logic             held_mark [CAPACITY];
  logic [POS_W-1:0] next_pos;
  logic [POS_W-1:0] end_pos;
  logic             end_seen;
  logic             closed;
  int               fill_level;
  int               pending_cnt;
  logic [CFG_W-1:0] cap_reg;

  result_t step_results[$];
  result_t expected_results[$];
  item_t   plan[$];

  int idle_pct;
  int items_sent;
  int results_seen;
  int bytes_seen;
  int mismatches;
  int quiet_cycles;

  // Directed table; typed results hold for capacity 32 right after reset.
  step_row_t directed_rows [N_DIRECTED] = '{
    '{'{FUNC_CONSUME, 32'd0, 8'h00, 1'b0, 1'b0, 6'd0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 6'd0}},
    '{'{FUNC_SEGMENT, 32'd5, 8'hFF, 1'b0, 1'b0, 6'd0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1}},
    // same position again: stored byte kept
    '{'{FUNC_SEGMENT, 32'd5, 8'h11, 1'b0, 1'b0, 6'd0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1}},
    // first position past the window
    '{'{FUNC_SEGMENT, 32'd32, 8'h5A, 1'b0, 1'b0, 6'd0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1}},
    '{'{FUNC_SEGMENT, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 6'd0}, 1'b1,
      '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1}},
    '{'{FUNC_SEGMENT, 32'd0, 8'h00, 1'b0, 1'b0, 6'd0}, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b0, 6'd1}},
    '{'{FUNC_SEGMENT, 32'd4, 8'hA4, 1'b0, 1'b0, 6'd0}, 1'b0, '0},
    '{'{FUNC_SEGMENT, 32'd3, 8'hA3, 1'b0, 1'b0, 6'd0}, 1'b0, '0},
    '{'{FUNC_SEGMENT, 32'd2, 8'hA2, 1'b0, 1'b0, 6'd0}, 1'b0, '0},
    '{'{FUNC_SEGMENT, 32'd1, 8'hA1, 1'b0, 1'b0, 6'd0}, 1'b0, '0},
    // consume more than the writer holds
    '{'{FUNC_CONSUME, 32'd0, 8'h00, 1'b0, 1'b0, 6'd63}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 6'd0}},
    '{'{FUNC_SEGMENT, 32'h8000_0000, 8'h77, 1'b1, 1'b1, 6'd0}, 1'b1,
      '{1'b0, 8'h00, 1'b1, 1'b0, 6'd0}},
    // end mark behind the release point replaces the far one
    '{'{FUNC_SEGMENT, 32'd2, 8'h00, 1'b1, 1'b1, 6'd0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 6'd0}},
    '{'{FUNC_CONSUME, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 6'd0}, 1'b1,
      '{1'b0, 8'h00, 1'b1, 1'b0, 6'd0}},
    // last position inside the window
    '{'{FUNC_SEGMENT, 32'd37, 8'h3C, 1'b0, 1'b0, 6'd0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1}},
    '{'{FUNC_SEGMENT, 32'd6, 8'hC3, 1'b0, 1'b0, 6'd0}, 1'b0, '0},
    '{'{FUNC_SEGMENT, 32'h7000_0000, 8'h5A, 1'b0, 1'b1, 6'd0}, 1'b1,
      '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1}},
    '{'{FUNC_CONSUME, 32'd0, 8'h00, 1'b0, 1'b0, 6'd32}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 6'd1}}
  };

  logic [CFG_W-1:0] phase_cap [N_PHASES] = '{6'd32, 6'd7, 6'd1, 6'd63, 6'd0, 6'd20, 6'd32};
  int phase_items [N_PHASES] = '{50, 50, 40, 50, 20, 50, 60};

  function automatic int eff_cap();
    return (int'(cap_reg) < CAPACITY) ? int'(cap_reg) : CAPACITY;
  endfunction

  function automatic int window_room();
    return (fill_level < eff_cap()) ? eff_cap() - fill_level : 0;
  endfunction

  function automatic item_t byte_at(input logic [31:0] pos);
    item_t it;
    it = '0;
    it.func = FUNC_SEGMENT;
    it.stream_index = pos;
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  // One item through the reassembler; results land in step_results.
  task automatic reassemble_step(input item_t it);
    logic [POS_W-1:0] pos;
    logic [SLOT_W-1:0] slot;
    logic [7:0] released[$];
    pos = {1'b0, it.stream_index};
    if (it.func == FUNC_SEGMENT) begin
      if (!closed) begin
        slot = pos[SLOT_W-1:0];
        if (!it.no_byte && pos >= next_pos && (pos - next_pos) < POS_W'(window_room()) &&
            !held_mark[slot]) begin
          held_byte[slot] = it.data_byte;
          held_mark[slot] = 1'b1;
          pending_cnt++;
        end
        if (it.ends_stream) begin
          end_seen = 1'b1;
          end_pos = pos + (it.no_byte ? 33'd0 : 33'd1);
        end
      end
    end else begin
      fill_level = (int'(it.consume_count) < fill_level) ?
                   fill_level - int'(it.consume_count) : 0;
    end
    while (released.size() < MAX_OUT && next_pos[32] == 1'b0 && fill_level < eff_cap()) begin
      slot = next_pos[SLOT_W-1:0];
      if (!held_mark[slot]) break;
      released.push_back(held_byte[slot]);
      held_mark[slot] = 1'b0;
      next_pos++;
      fill_level++;
      if (pending_cnt > 0) pending_cnt--;
    end
    if (end_seen && next_pos == end_pos) closed = 1'b1;
    step_results.delete();
    if (released.size() == 0) begin
      step_results.push_back('{1'b0, 8'h00, 1'b1, closed, 6'(pending_cnt)});
    end else begin
      foreach (released[k])
        step_results.push_back('{1'b1, released[k], (k == released.size() - 1), closed,
                                 6'(pending_cnt)});
    end
  endtask

  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    reassemble_step(it);
    if (typed) expected_results.push_back(typed_res);
    else foreach (step_results[k]) expected_results.push_back(step_results[k]);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fill the whole window out of order, the byte at the release point last.
  task automatic plan_burst();
    int room;
    int j;
    int tmp;
    logic [31:0] base;
    int order[$];
    room = window_room();
    base = next_pos[31:0];
    for (int k = 1; k < room; k++) order.push_back(k);
    for (int k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) plan.push_back(byte_at(base + order[k]));
    if (room > 0) plan.push_back(byte_at(base));
  endtask

  task automatic plan_random();
    int pick;
    item_t it;
    logic [31:0] ne;
    ne = next_pos[31:0];
    pick = $urandom_range(99);
    it = byte_at(ne + $urandom_range(0, eff_cap() + 2));
    if (pick < 40) begin
      if ($urandom_range(9) == 0 && ne >= 8) it.stream_index = ne - $urandom_range(1, 8);
    end else if (pick < 55) begin
      plan_burst();
    end else if (pick < 78) begin
      it.func = FUNC_CONSUME;
      it.stream_index = $urandom;
      it.consume_count = ($urandom_range(5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
    end else if (pick < 92) begin
      it.func = 1'($urandom_range(1));
      it.stream_index = $urandom;
      it.no_byte = 1'($urandom_range(1));
      it.ends_stream = 1'($urandom_range(1));
      it.consume_count = 6'($urandom);
      // a random end mark must stay far from the release point
      if (it.func == FUNC_SEGMENT && it.ends_stream) it.stream_index[31] = 1'b1;
    end else begin
      it.no_byte = 1'($urandom_range(1));
      it.ends_stream = 1'b1;
      if ($urandom_range(1) == 0 || ne < 2)
        it.stream_index = ne + 32'h0010_0000 + $urandom_range(0, 4095);
      else
        it.stream_index = $urandom_range(0, ne - 2);
    end
    if (pick < 40 || pick >= 55) plan.push_back(it);
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t: %s: expected valid=%0d byte=%02h last=%0d closed=%0d pending=%0d, ",
             $time, what, want.out_valid, want.out_byte, want.last_of_run,
             want.stream_closed, want.pending_bytes);
      $display("got valid=%0d byte=%02h last=%0d closed=%0d pending=%0d",
               got.out_valid, got.out_byte, got.last_of_run, got.stream_closed,
               got.pending_bytes);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      results_seen++;
      if (result.out_valid) bytes_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, result);
      end else if (result.out_valid != expected_results[0].out_valid ||
                   result.out_byte != expected_results[0].out_byte ||
                   result.last_of_run != expected_results[0].last_of_run ||
                   result.stream_closed != expected_results[0].stream_closed ||
                   result.pending_bytes != expected_results[0].pending_bytes) begin
        flag_mismatch("result mismatch", expected_results[0], result);
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    item_t it;
    logic [POS_W-1:0] end_at;
    logic [31:0] base;
    int random_sent;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    foreach (held_mark[k]) held_mark[k] = 1'b0;
    foreach (held_byte[k]) held_byte[k] = 8'h00;
    next_pos = '0;
    end_pos = '0;
    end_seen = 1'b0;
    closed = 1'b0;
    fill_level = 0;
    pending_cnt = 0;
    cap_reg = CFG_RESET;
    idle_pct = 6;
    items_sent = 0;
    results_seen = 0;
    bytes_seen = 0;
    mismatches = 0;
    quiet_cycles = 0;
    random_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].res);

    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(phase_cap[p]);
      for (int n = 0; n < phase_items[p]; n++) begin
        while (plan.size() == 0) plan_random();
        idle_pct = (random_sent < 107) ? 6 : (random_sent < 214) ? 52 : 0;
        send_item(plan.pop_front(), 1'b0, '0);
        random_sent++;
      end
      // leave the writer full so the next capacity may fall below it
      plan_burst();
      while (plan.size() != 0) send_item(plan.pop_front(), 1'b0, '0);
    end

    // Close the stream: end at the first unheld position past the release point,
    // then fill the gap from the top down. The second consume empties the writer
    // again if the first one let a long run refill it.
    it = '0;
    it.func = FUNC_CONSUME;
    it.consume_count = 6'd63;
    repeat (2) send_item(it, 1'b0, '0);
    end_at = next_pos + 33'd1;
    while (held_mark[end_at[SLOT_W-1:0]]) end_at++;
    base = next_pos[31:0];
    it = '0;
    it.func = FUNC_SEGMENT;
    it.stream_index = end_at[31:0];
    it.no_byte = 1'b1;
    it.ends_stream = 1'b1;
    send_item(it, 1'b0, '0);
    for (int d = int'(end_at - {1'b0, base}) - 1; d >= 0; d--)
      send_item(byte_at(base + d), 1'b0, '0);
    // after close only consume transfers change anything
    for (int n = 0; n < 8; n++) begin
      while (plan.size() == 0) plan_random();
      send_item(plan.pop_front(), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end

    $display("Covered %0d items (%0d directed) over %0d capacity settings, 0 through 63",
             items_sent, N_DIRECTED, N_PHASES);
    $display("Checked %0d results, %0d released bytes; stream %s at the end",
             results_seen, bytes_seen, closed ? "closed" : "open");
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
